### sv/abrl_pkg.sv
// Shared types, constants and codes for the A/B record log scan block.
package abrl_pkg;

  localparam int SLOT_W = 6;
  localparam int SEQ_W = 32;
  localparam int SLOTS_PER_PAGE_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 4;

  // slot_status codes as reported by the slot reader
  localparam logic [1:0] SLOT_VALID = 2'd0;
  localparam logic [1:0] SLOT_EMPTY = 2'd1;
  localparam logic [1:0] SLOT_DAMAGED = 2'd2;

  // read_status codes
  localparam logic [1:0] RS_OK = 2'd0;
  localparam logic [1:0] RS_EMPTY = 2'd1;
  localparam logic [1:0] RS_CRC = 2'd2;

  // classified operation handed from front to back
  localparam logic [1:0] OP_VALID = 2'd0;
  localparam logic [1:0] OP_EMPTY = 2'd1;
  localparam logic [1:0] OP_DAMAGED = 2'd2;
  localparam logic [1:0] OP_SKIP = 2'd3;

  typedef struct packed {
    logic              page;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        op;
    logic [SEQ_W-1:0]  seq;
    logic              last;
  } item_t;

  typedef struct packed {
    logic              has_valid;
    logic              has_empty;
    logic              has_damaged;
    logic [SEQ_W-1:0]  newest_seq;
    logic [SLOT_W-1:0] newest_slot;
    logic [SLOT_W-1:0] first_empty;
  } page_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

### sv/abrl_front.sv
// Front end: input register that classifies each slot report.
module abrl_front #(
  parameter int SLOTS_PER_PAGE = abrl_pkg::SLOTS_PER_PAGE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          page_select,
  input  logic [abrl_pkg::SLOT_W-1:0]   slot_number,
  input  logic [1:0]                    slot_status,
  input  logic [abrl_pkg::SEQ_W-1:0]    sequence_req,
  input  logic                          final_report,
  input  abrl_pkg::queue_status_t       q_status,
  output logic                          push,
  output abrl_pkg::item_t               push_item
);
  import abrl_pkg::*;

  localparam int CMP_W = $clog2(SLOTS_PER_PAGE + 1) + SLOT_W;

  logic  held;
  logic  held_next;
  item_t item;
  item_t item_next;
  logic  accept;
  logic  slot_ok;

  assign push = held && !q_status.full;
  assign in_stall = held && q_status.full;
  assign accept = in_valid && !in_stall;
  assign push_item = item;

  assign slot_ok = CMP_W'(slot_number) < CMP_W'(SLOTS_PER_PAGE);

  always_comb begin
    item_next.page = page_select;
    item_next.slot = slot_number;
    item_next.seq = sequence_req;
    item_next.last = final_report;
    if (!slot_ok) begin
      item_next.op = OP_SKIP;
    end else begin
      unique case (slot_status)
        SLOT_VALID: item_next.op = OP_VALID;
        SLOT_EMPTY: item_next.op = OP_EMPTY;
        default:    item_next.op = OP_DAMAGED;  // code 3 counts as damaged
      endcase
    end
  end

  always_comb begin
    if (accept) begin
      held_next = 1'b1;
    end else if (push) begin
      held_next = 1'b0;
    end else begin
      held_next = held;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

### sv/abrl_queue.sv
// Short FIFO of classified slot reports between front and back.
module abrl_queue #(
  parameter int QUEUE_DEPTH = abrl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  abrl_pkg::item_t         push_item,
  input  logic                    pop,
  output abrl_pkg::item_t         head,
  output abrl_pkg::queue_status_t status
);
  import abrl_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  item_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full = count == CNT_W'(QUEUE_DEPTH);
  assign status.empty = count == '0;
  assign do_push = push && !status.full;
  assign do_pop = pop && !status.empty;
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

### sv/abrl_back.sv
// Back end: per-page trackers, end-of-scan snapshot and result register.
module abrl_back (
  input  logic                         clk,
  input  logic                         rst,
  input  abrl_pkg::item_t              head,
  input  abrl_pkg::queue_status_t      q_status,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   read_status,
  output logic                         newest_page,
  output logic [abrl_pkg::SLOT_W-1:0]  newest_slot,
  output logic [abrl_pkg::SEQ_W-1:0]   newest_sequence,
  output logic [abrl_pkg::SEQ_W-1:0]   next_sequence,
  output logic                         write_page,
  output logic [abrl_pkg::SLOT_W-1:0]  write_slot,
  output logic                         erase_needed
);
  import abrl_pkg::*;

  page_state_t pages [2];
  page_state_t pages_next [2];
  page_state_t snap [2];
  logic        snap_valid;
  logic        snap_move;
  logic        out_load;

  logic [SEQ_W-1:0] diff [2];
  logic [SEQ_W-1:0] page_diff;
  logic [SEQ_W-1:0] seq_inc [2];
  logic             act;
  logic             any_valid;

  logic [1:0]        rs_c;
  logic              np_c;
  logic [SLOT_W-1:0] ns_c;
  logic [SEQ_W-1:0]  nseq_c;
  logic [SEQ_W-1:0]  nxt_c;
  logic              tp_c;
  logic [SLOT_W-1:0] ts_c;
  logic              er_c;

  // result stage moves when the output register is free or being drained
  assign out_load = !out_valid || !out_stall;
  assign snap_move = snap_valid && out_load;
  // a last beat needs the snapshot slot
  assign pop = !q_status.empty && (!head.last || !snap_valid || snap_move);

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      pages_next[p] = pages[p];
      diff[p] = head.seq - pages[p].newest_seq;
      if (head.page == 1'(p)) begin
        case (head.op)
          OP_VALID: begin
            if (!pages[p].has_valid || !diff[p][SEQ_W-1]) begin
              pages_next[p].newest_seq = head.seq;
              pages_next[p].newest_slot = head.slot;
            end
            pages_next[p].has_valid = 1'b1;
          end
          OP_EMPTY: begin
            if (!pages[p].has_empty) begin
              pages_next[p].first_empty = head.slot;
            end
            pages_next[p].has_empty = 1'b1;
          end
          OP_DAMAGED: pages_next[p].has_damaged = 1'b1;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pages[0] <= '0;
      pages[1] <= '0;
      snap_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (head.last) begin
          pages[0] <= '0;
          pages[1] <= '0;
        end else begin
          pages[0] <= pages_next[0];
          pages[1] <= pages_next[1];
        end
      end
      if (pop && head.last) begin
        snap_valid <= 1'b1;
      end else if (snap_move) begin
        snap_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      snap[0] <= pages_next[0];
      snap[1] <= pages_next[1];
    end
  end

  // result from the snapshot: page pick and both increments in parallel
  assign page_diff = snap[0].newest_seq - snap[1].newest_seq;
  assign seq_inc[0] = snap[0].newest_seq + 1'b1;
  assign seq_inc[1] = snap[1].newest_seq + 1'b1;
  assign any_valid = snap[0].has_valid || snap[1].has_valid;

  always_comb begin
    if (snap[0].has_valid && snap[1].has_valid) begin
      act = page_diff[SEQ_W-1];  // ties go to page A
    end else begin
      act = !snap[0].has_valid;
    end
  end

  always_comb begin
    rs_c = RS_OK;
    np_c = 1'b0;
    ns_c = '0;
    nseq_c = '0;
    nxt_c = SEQ_W'(1);
    tp_c = 1'b0;
    ts_c = '0;
    er_c = 1'b1;
    if (any_valid) begin
      np_c = act;
      ns_c = snap[act].newest_slot;
      nseq_c = snap[act].newest_seq;
      nxt_c = seq_inc[act];
      if (!snap[act].has_damaged && snap[act].has_empty) begin
        tp_c = act;
        ts_c = snap[act].first_empty;
        er_c = 1'b0;
      end else begin
        tp_c = !act;
      end
    end else if (snap[0].has_damaged || snap[1].has_damaged) begin
      rs_c = RS_CRC;
    end else begin
      rs_c = RS_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_move) begin
      read_status <= rs_c;
      newest_page <= np_c;
      newest_slot <= ns_c;
      newest_sequence <= nseq_c;
      next_sequence <= nxt_c;
      write_page <= tp_c;
      write_slot <= ts_c;
      erase_needed <= er_c;
    end
  end

endmodule

### sv/ab_record_log_scan_and_target.sv
// Top level of the A/B record log scan and write-target block.
//
// Usage: feed one slot report per beat on the input channel (in_valid /
// in_stall), covering the slots of pages A and B in any order. Mark the last
// report of a scan with final_report. One result beat then leaves on the
// output channel (out_valid / out_stall): read status, newest record location
// and sequence, next sequence, and the page/slot to write next with the
// erase flag. Reports without the final mark produce no beat.
// Throughput: one report per cycle while in_stall is low. The front register
// classifies a report, a short FIFO decouples it from the per-page trackers,
// and the result is built from a snapshot of the trackers into the output
// register. The final report passes the front register, a FIFO entry, the
// snapshot and the output register in that order. Tracker state clears on
// the final beat, so the next scan may follow in the very next cycle.
// Reset: synchronous; empties the FIFO and clears trackers and out_valid.
// When the receiver stalls, the result holds; the snapshot, FIFO and front
// register keep absorbing reports until they fill, then in_stall rises.
module ab_record_log_scan_and_target #(
  parameter int SLOTS_PER_PAGE = abrl_pkg::SLOTS_PER_PAGE_DEF,
  parameter int QUEUE_DEPTH = abrl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         page_select,
  input  logic [abrl_pkg::SLOT_W-1:0]  slot_number,
  input  logic [1:0]                   slot_status,
  input  logic [abrl_pkg::SEQ_W-1:0]   sequence_req,
  input  logic                         final_report,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   read_status,
  output logic                         newest_page,
  output logic [abrl_pkg::SLOT_W-1:0]  newest_slot,
  output logic [abrl_pkg::SEQ_W-1:0]   newest_sequence,
  output logic [abrl_pkg::SEQ_W-1:0]   next_sequence,
  output logic                         write_page,
  output logic [abrl_pkg::SLOT_W-1:0]  write_slot,
  output logic                         erase_needed
);
  import abrl_pkg::*;

  logic          push;
  item_t         push_item;
  logic          pop;
  item_t         head;
  queue_status_t q_status;

  abrl_front #(
    .SLOTS_PER_PAGE(SLOTS_PER_PAGE)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .page_select (page_select),
    .slot_number (slot_number),
    .slot_status (slot_status),
    .sequence_req(sequence_req),
    .final_report(final_report),
    .q_status    (q_status),
    .push        (push),
    .push_item   (push_item)
  );

  abrl_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  abrl_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .q_status       (q_status),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_status    (read_status),
    .newest_page    (newest_page),
    .newest_slot    (newest_slot),
    .newest_sequence(newest_sequence),
    .next_sequence  (next_sequence),
    .write_page     (write_page),
    .write_slot     (write_slot),
    .erase_needed   (erase_needed)
  );

endmodule

### sv/abrl_checker.sv
// Port-level checker for the A/B record log scan block, with its bind.
module abrl_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [1:0]                   read_status,
  input logic                         newest_page,
  input logic [abrl_pkg::SEQ_W-1:0]   newest_sequence,
  input logic [abrl_pkg::SEQ_W-1:0]   next_sequence,
  input logic                         write_page,
  input logic                         erase_needed
);
  import abrl_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(next_sequence)
      && $stable(read_status) && $stable(write_page))
    else $error("result beat changed while stalled");

  a_no_beat_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat right after reset");

  a_next_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_status == RS_OK |-> next_sequence == newest_sequence + 1'b1)
    else $error("next sequence is not newest plus one");

  a_none_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_status != RS_OK |->
      next_sequence == SEQ_W'(1) && newest_sequence == '0
      && write_page == 1'b0 && erase_needed)
    else $error("bad result when no valid record");

  a_no_erase_same_page: assert property (@(posedge clk) disable iff (rst)
    out_valid && !erase_needed |-> read_status == RS_OK && write_page == newest_page)
    else $error("append target off the newest page");

endmodule

bind ab_record_log_scan_and_target abrl_checker u_abrl_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .read_status    (read_status),
  .newest_page    (newest_page),
  .newest_sequence(newest_sequence),
  .next_sequence  (next_sequence),
  .write_page     (write_page),
  .erase_needed   (erase_needed)
);
